>>> sv/bole_pkg.sv
// Shared types and codes for the bounded ordered list engine.
package bole_pkg;

   localparam int KEY_W = 32;

   // operation codes carried in req.mode
   localparam logic [2:0] MODE_PUSH_HEAD = 3'd0;
   localparam logic [2:0] MODE_PUSH_TAIL = 3'd1;
   localparam logic [2:0] MODE_INSERT    = 3'd2;
   localparam logic [2:0] MODE_POP_HEAD  = 3'd3;
   localparam logic [2:0] MODE_POP_TAIL  = 3'd4;
   localparam logic [2:0] MODE_REMOVE    = 3'd5;
   localparam logic [2:0] MODE_READ      = 3'd6;

   // status codes carried in rsp.status
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_EMPTY = 2'd1;
   localparam logic [1:0] STAT_MISS  = 2'd2;
   localparam logic [1:0] STAT_FULL  = 2'd3;

   typedef struct packed {
      logic [2:0]              mode;
      logic signed [KEY_W-1:0] key;
      logic [3:0]              index;
   } req_type;

   typedef struct packed {
      logic [1:0]              status;
      logic signed [KEY_W-1:0] read_key;
      logic [4:0]              count;
      logic signed [KEY_W-1:0] head_key;
      logic signed [KEY_W-1:0] tail_key;
   } rsp_type;

   // what every cell does with its entry on a request
   typedef enum logic [2:0] {
      CELL_NONE,
      CELL_INS_HEAD,
      CELL_INS_AT_COUNT,
      CELL_INS_SCAN,
      CELL_DEL_HEAD,
      CELL_DEL_MATCH
   } cell_op_type;

   typedef struct packed {
      logic        en;
      cell_op_type op;
   } cell_ctrl_type;

   typedef struct packed {
      logic gt;       // request key below this entry
      logic lt_last;  // this is the tail and it is below the request key
   } cell_flag_type;

endpackage

>>> sv/bole_cell.sv
// One list position: holds an entry and shifts it to or from its neighbors.
module bole_cell #(
   parameter int IDX   = 0,
   parameter int CNT_W = 5
) (
   input  logic                                clock,
   input  bole_pkg::cell_ctrl_type             ctrl,
   input  logic signed [bole_pkg::KEY_W-1:0]   key,
   input  logic [3:0]                          index,
   input  logic [CNT_W-1:0]                    count,
   input  logic [CNT_W-1:0]                    count_next,
   input  logic signed [bole_pkg::KEY_W-1:0]   left_key,
   input  logic signed [bole_pkg::KEY_W-1:0]   right_key,
   input  logic                                ins_seen_in,
   output logic                                ins_seen_out,
   input  logic                                rm_seen_in,
   output logic                                rm_seen_out,
   input  logic signed [bole_pkg::KEY_W-1:0]   rd_in,
   output logic signed [bole_pkg::KEY_W-1:0]   rd_out,
   input  logic signed [bole_pkg::KEY_W-1:0]   tail_in,
   output logic signed [bole_pkg::KEY_W-1:0]   tail_out,
   output bole_pkg::cell_flag_type             flag,
   output logic signed [bole_pkg::KEY_W-1:0]   key_q,
   output logic signed [bole_pkg::KEY_W-1:0]   key_next
);

   localparam logic [CNT_W-1:0] POS      = CNT_W'(IDX);
   localparam logic [CNT_W-1:0] POS_NEXT = CNT_W'(IDX + 1);
   localparam logic [31:0]      POS32    = 32'(IDX);

   logic signed [bole_pkg::KEY_W-1:0] key_ff, key_in;
   logic occ, last, last_next, lt, eq, ins_hit, rm_hit;

   assign occ       = POS < count;
   assign last      = count == POS_NEXT;
   assign last_next = count_next == POS_NEXT;
   assign lt        = key_ff < key;
   assign eq        = occ && (key_ff == key);

   assign flag.gt      = key < key_ff;
   assign flag.lt_last = last && lt;

   assign rm_hit      = eq;
   assign rm_seen_out = rm_seen_in | rm_hit;

   // insert point: first hit along the row, cells past it shift right
   always_comb begin
      case (ctrl.op)
         bole_pkg::CELL_INS_HEAD:     ins_hit = (IDX == 0);
         bole_pkg::CELL_INS_AT_COUNT: ins_hit = (count == POS);
         bole_pkg::CELL_INS_SCAN:
            ins_hit = ((IDX != 0) && occ && !lt) || (count == POS);
         default:                     ins_hit = 1'b0;
      endcase
   end
   assign ins_seen_out = ins_seen_in | ins_hit;

   always_comb begin
      case (ctrl.op)
         bole_pkg::CELL_INS_HEAD, bole_pkg::CELL_INS_AT_COUNT,
         bole_pkg::CELL_INS_SCAN: begin
            if (ins_seen_in) begin
               key_in = left_key;
            end else if (ins_hit) begin
               key_in = key;
            end else begin
               key_in = key_ff;
            end
         end
         bole_pkg::CELL_DEL_HEAD:  key_in = right_key;
         bole_pkg::CELL_DEL_MATCH: key_in = (rm_seen_in | rm_hit) ? right_key : key_ff;
         default:                  key_in = key_ff;
      endcase
   end

   assign rd_out   = rd_in | ((occ && (32'(index) == POS32)) ? key_ff : '0);
   assign tail_out = tail_in | (last_next ? key_in : '0);

   assign key_q    = key_ff;
   assign key_next = key_in;

   always_ff @(posedge clock) begin
      if (ctrl.en) begin
         key_ff <= key_in;
      end
   end

endmodule

>>> sv/bounded_ordered_list_engine.sv
// Top level of the bounded ordered list engine: a row of list cells and the response register.
//
//   channel | direction | ports                        | payload
//   req     | in        | req_valid, req_stall, req    | bole_pkg::req_type
//   rsp     | out       | rsp_valid, rsp_stall, rsp    | bole_pkg::rsp_type
//
// Every request completes at acceptance: all cells compare against the key at
// once and shift in the same edge that registers the response.
// A new request is taken while a response waits, unless that response is stalled.
// Reset empties the list at once; entries past the count are never shown.
// The longest path is the priority chain across the row of DEPTH cells.
module bounded_ordered_list_engine #(
   parameter int DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  bole_pkg::req_type req,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output bole_pkg::rsp_type rsp
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [CNT_W-1:0]                  count_ff, count_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   bole_pkg::rsp_type                 rsp_ff, rsp_in;
   logic                              accept, is_push, is_take, full, empty, found, idx_ok;
   logic [1:0]                        status;
   bole_pkg::cell_ctrl_type           ctrl;
   logic [DEPTH:0]                    ins_chain, rm_chain;
   logic signed [bole_pkg::KEY_W-1:0] rd_chain   [DEPTH+1];
   logic signed [bole_pkg::KEY_W-1:0] tail_chain [DEPTH+1];
   logic signed [bole_pkg::KEY_W-1:0] key_q      [DEPTH];
   logic signed [bole_pkg::KEY_W-1:0] key_nx     [DEPTH];
   bole_pkg::cell_flag_type           flags      [DEPTH];
   logic [DEPTH-1:0]                  lt_last_vec;

   assign ins_chain[0]  = 1'b0;
   assign rm_chain[0]   = 1'b0;
   assign rd_chain[0]   = '0;
   assign tail_chain[0] = '0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [bole_pkg::KEY_W-1:0] left_key, right_key;
      if (i == 0) begin : g_first
         assign left_key = req.key;
      end else begin : g_mid
         assign left_key = key_q[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_key = key_q[i];
      end else begin : g_inner
         assign right_key = key_q[i+1];
      end
      assign lt_last_vec[i] = flags[i].lt_last;

      bole_cell #(
         .IDX   (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock        (clock),
         .ctrl         (ctrl),
         .key          (req.key),
         .index        (req.index),
         .count        (count_ff),
         .count_next   (count_in),
         .left_key     (left_key),
         .right_key    (right_key),
         .ins_seen_in  (ins_chain[i]),
         .ins_seen_out (ins_chain[i+1]),
         .rm_seen_in   (rm_chain[i]),
         .rm_seen_out  (rm_chain[i+1]),
         .rd_in        (rd_chain[i]),
         .rd_out       (rd_chain[i+1]),
         .tail_in      (tail_chain[i]),
         .tail_out     (tail_chain[i+1]),
         .flag         (flags[i]),
         .key_q        (key_q[i]),
         .key_next     (key_nx[i])
      );
   end

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign is_push = (req.mode == bole_pkg::MODE_PUSH_HEAD) ||
                    (req.mode == bole_pkg::MODE_PUSH_TAIL) ||
                    (req.mode == bole_pkg::MODE_INSERT);
   assign is_take = (req.mode == bole_pkg::MODE_POP_HEAD) ||
                    (req.mode == bole_pkg::MODE_POP_TAIL) ||
                    (req.mode == bole_pkg::MODE_REMOVE);
   assign full    = count_ff == CNT_W'(DEPTH);
   assign empty   = count_ff == '0;
   assign found   = rm_chain[DEPTH];
   assign idx_ok  = 32'(req.index) < 32'(count_ff);

   always_comb begin
      if (is_push && full) begin
         status = bole_pkg::STAT_FULL;
      end else if (is_take && empty) begin
         status = bole_pkg::STAT_EMPTY;
      end else if ((req.mode == bole_pkg::MODE_REMOVE) && !found) begin
         status = bole_pkg::STAT_MISS;
      end else if ((req.mode == bole_pkg::MODE_READ) && !idx_ok) begin
         status = bole_pkg::STAT_MISS;
      end else begin
         status = bole_pkg::STAT_OK;
      end
   end

   always_comb begin
      ctrl.en  = accept;
      ctrl.op  = bole_pkg::CELL_NONE;
      count_in = count_ff;
      if (status == bole_pkg::STAT_OK) begin
         case (req.mode)
            bole_pkg::MODE_PUSH_HEAD: ctrl.op = bole_pkg::CELL_INS_HEAD;
            bole_pkg::MODE_PUSH_TAIL: ctrl.op = bole_pkg::CELL_INS_AT_COUNT;
            bole_pkg::MODE_INSERT: begin
               // below the head, above the tail, or scan for the spot
               if (empty || flags[0].gt) begin
                  ctrl.op = bole_pkg::CELL_INS_HEAD;
               end else if (|lt_last_vec) begin
                  ctrl.op = bole_pkg::CELL_INS_AT_COUNT;
               end else begin
                  ctrl.op = bole_pkg::CELL_INS_SCAN;
               end
            end
            bole_pkg::MODE_POP_HEAD: ctrl.op = bole_pkg::CELL_DEL_HEAD;
            bole_pkg::MODE_REMOVE:   ctrl.op = bole_pkg::CELL_DEL_MATCH;
            default:                 ctrl.op = bole_pkg::CELL_NONE;
         endcase
         if (is_push) begin
            count_in = count_ff + CNT_W'(1);
         end else if (is_take) begin
            count_in = count_ff - CNT_W'(1);
         end
      end
   end

   always_comb begin
      rsp_in.status   = status;
      rsp_in.read_key = ((req.mode == bole_pkg::MODE_READ) && (status == bole_pkg::STAT_OK)) ?
                        rd_chain[DEPTH] : '0;
      rsp_in.count    = 5'(count_in);
      rsp_in.head_key = (count_in != '0) ? key_nx[0] : '0;
      rsp_in.tail_key = tail_chain[DEPTH];
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

>>> sv/bole_checker.sv
// Port-level checks for the bounded ordered list engine, with its bind.
module bole_checker #(
   parameter int DEPTH = 16
) (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input bole_pkg::req_type req,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input bole_pkg::rsp_type rsp
);

   // a stalled request holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req))
      else $error("stalled request changed");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
      else $error("stalled response changed");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 32'(rsp.count) <= DEPTH)
      else $error("count beyond depth");

   a_empty_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp.count == 5'd0) |-> (rsp.head_key == '0) && (rsp.tail_key == '0))
      else $error("empty list shows a head or tail");

   a_single_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp.count == 5'd1) |-> rsp.head_key == rsp.tail_key)
      else $error("single entry with head and tail apart");

endmodule

bind bounded_ordered_list_engine bole_checker #(
   .DEPTH (DEPTH)
) u_bole_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req       (req),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp       (rsp)
);

>>> sim/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the bounded ordered list engine.
module tb;

   localparam int DEPTH       = 16;
   localparam int RANDOM_OPS  = 1500;
   localparam int HOLD_CYCLES = 150;
   localparam int IDLE_LIMIT  = 2000;
   localparam int SETTLE      = 10;
   localparam logic [2:0] MODE_UNUSED = 3'd7;

   typedef struct {
      bole_pkg::req_type op;
      bit      hold_rsp;    // receiver holds off once this request goes out
      bit      wait_drain;  // sender waits until every response is back
   } list_job_type;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   bole_pkg::req_type req       = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   bole_pkg::rsp_type rsp;

   list_job_type       job_backlog[$];
   bole_pkg::rsp_type  outcome_q[$];
   logic signed [31:0] list_keys[$];

   bole_pkg::rsp_type predicted;
   bole_pkg::rsp_type want;
   bit         req_taken = 1'b0;
   bit         hold_go   = 1'b0;   // toggles once per requested hold-off
   bit         hold_ack  = 1'b0;
   int         burst_left = 0;
   int         gap_left = 0;
   int         hold_left = 0;
   int         stall_phase_left = 0;
   int         stall_style = 0;
   logic [7:0] stall_pattern = 8'h00;
   int         idle_cycles = 0;
   int         mismatches = 0;
   int         n_requests = 0;
   int         n_responses = 0;
   int         n_full = 0;
   int         n_empty = 0;
   int         n_miss = 0;
   int         peak_count = 0;
   int         mode_seen[8];

   bounded_ordered_list_engine #(.DEPTH(DEPTH)) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // expected response of one request; updates the shadow list
   function automatic bole_pkg::rsp_type list_op_outcome(input bole_pkg::req_type r);
      bole_pkg::rsp_type  o;
      int                 n;
      int                 pos;
      int                 i;
      logic signed [31:0] k;
      o = '0;
      n = list_keys.size();
      k = r.key;
      if (r.mode <= bole_pkg::MODE_INSERT && n >= DEPTH) begin
         o.status = bole_pkg::STAT_FULL;
      end else if (r.mode >= bole_pkg::MODE_POP_HEAD && r.mode <= bole_pkg::MODE_REMOVE &&
                   n == 0) begin
         o.status = bole_pkg::STAT_EMPTY;
      end else begin
         case (r.mode)
            bole_pkg::MODE_PUSH_HEAD: list_keys.push_front(k);
            bole_pkg::MODE_PUSH_TAIL: list_keys.push_back(k);
            bole_pkg::MODE_INSERT: begin
               if (n == 0 || k < list_keys[0]) begin
                  pos = 0;
               end else if (list_keys[n-1] < k) begin
                  pos = n;
               end else begin
                  // equal to the head lands right after it
                  pos = 1;
                  while (pos < n && list_keys[pos] < k) pos++;
               end
               list_keys.insert(pos, k);
            end
            bole_pkg::MODE_POP_HEAD: list_keys.delete(0);
            bole_pkg::MODE_POP_TAIL: list_keys.delete(n - 1);
            bole_pkg::MODE_REMOVE: begin
               pos = -1;
               for (i = 0; i < n && pos < 0; i++) begin
                  if (list_keys[i] == k) pos = i;
               end
               if (pos >= 0) list_keys.delete(pos);
               else o.status = bole_pkg::STAT_MISS;
            end
            bole_pkg::MODE_READ: begin
               if (r.index < n) o.read_key = list_keys[r.index];
               else o.status = bole_pkg::STAT_MISS;
            end
            default: ;
         endcase
      end
      n = list_keys.size();
      o.count = n[4:0];
      if (n != 0) begin
         o.head_key = list_keys[0];
         o.tail_key = list_keys[n-1];
      end
      return o;
   endfunction

   task automatic add_op(input logic [2:0] m, input logic signed [31:0] k,
                         input logic [3:0] idx, input bit hold, input bit drain);
      list_job_type j;
      j.op.mode    = m;
      j.op.key     = k;
      j.op.index   = idx;
      j.hold_rsp   = hold;
      j.wait_drain = drain;
      job_backlog.push_back(j);
   endtask

   // request driver: bursts with random gaps
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (gap_left > 0) begin
            gap_left = gap_left - 1;
            req_valid <= 1'b0;
         end else if (job_backlog.size() == 0 ||
                      (job_backlog[0].wait_drain && outcome_q.size() != 0)) begin
            req_valid <= 1'b0;
         end else begin
            req       <= job_backlog[0].op;
            req_valid <= 1'b1;
            if (job_backlog[0].hold_rsp) hold_go <= ~hold_go;
            if (burst_left > 0) begin
               burst_left = burst_left - 1;
            end else begin
               burst_left = $urandom_range(0, 40);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
         end
      end
   end

   // request acceptance and prediction
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            predicted = list_op_outcome(req);
            outcome_q.push_back(predicted);
            job_backlog.delete(0);
            n_requests++;
            mode_seen[req.mode]++;
            if (predicted.status == bole_pkg::STAT_FULL) n_full++;
            if (predicted.status == bole_pkg::STAT_EMPTY) n_empty++;
            if (predicted.status == bole_pkg::STAT_MISS) n_miss++;
            if (predicted.count > peak_count) peak_count = predicted.count;
         end
      end
   end

   // response stall: random phases, a rotating pattern, and long hold-offs on demand
   always @(negedge clock) begin
      if (hold_go != hold_ack) begin
         hold_left = HOLD_CYCLES;
         hold_ack  = hold_go;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         if (stall_phase_left == 0) begin
            stall_style      = $urandom_range(0, 3);
            stall_phase_left = $urandom_range(10, 80);
            stall_pattern    = 8'($urandom);
         end
         stall_phase_left = stall_phase_left - 1;
         case (stall_style)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= ($urandom_range(0, 1) == 0);
            default: begin
               rsp_stall <= stall_pattern[0];
               stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
            end
         endcase
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         n_responses++;
         if (outcome_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: response with nothing pending: status %0d count %0d",
                        $time, rsp.status, rsp.count);
         end else begin
            want = outcome_q.pop_front();
            if (rsp.status !== want.status || rsp.read_key !== want.read_key ||
                rsp.count !== want.count || rsp.head_key !== want.head_key ||
                rsp.tail_key !== want.tail_key) begin
               mismatches++;
               // expected/actual pairs
               if (mismatches <= 10)
                  $display("%0t: exp/act st %0d/%0d rd %0d/%0d cnt %0d/%0d hd %0d/%0d tl %0d/%0d",
                           $time,
                           want.status, rsp.status, want.read_key, rsp.read_key,
                           want.count, rsp.count, want.head_key, rsp.head_key,
                           want.tail_key, rsp.tail_key);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
         $display("bounded_ordered_list_engine verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      int                 gen_count;
      int                 style;
      int                 style_left;
      int                 r;
      int                 i;
      bit                 drain;
      logic [2:0]         m;
      logic signed [31:0] k;
      logic [3:0]         idx;
      logic signed [31:0] key_pool[$];

      // empty list corner cases
      add_op(bole_pkg::MODE_POP_HEAD, 32'sd0, 4'd0, 1'b0, 1'b0);
      add_op(bole_pkg::MODE_POP_TAIL, -32'sd1, 4'd15, 1'b0, 1'b0);
      add_op(bole_pkg::MODE_REMOVE, 32'sd5, 4'd0, 1'b0, 1'b0);
      add_op(bole_pkg::MODE_READ, 32'sd0, 4'd0, 1'b0, 1'b0);
      add_op(MODE_UNUSED, -32'sd1, 4'd15, 1'b0, 1'b0);
      // ordered insert: empty, above tail, below head, equal in the middle
      add_op(bole_pkg::MODE_INSERT, 32'sd0, 4'd0, 1'b0, 1'b0);
      add_op(bole_pkg::MODE_INSERT, 32'sh7fffffff, 4'd0, 1'b0, 1'b0);
      add_op(bole_pkg::MODE_INSERT, 32'sh80000000, 4'd0, 1'b0, 1'b0);
      add_op(bole_pkg::MODE_INSERT, 32'sd0, 4'd0, 1'b0, 1'b0);
      add_op(bole_pkg::MODE_PUSH_HEAD, -32'sd1, 4'd15, 1'b0, 1'b0);
      add_op(bole_pkg::MODE_PUSH_TAIL, 32'sd1, 4'd0, 1'b0, 1'b0);
      add_op(bole_pkg::MODE_READ, 32'sd0, 4'd0, 1'b0, 1'b0);
      add_op(bole_pkg::MODE_READ, 32'sd0, 4'd15, 1'b0, 1'b0);
      add_op(bole_pkg::MODE_READ, 32'sd0, 4'd3, 1'b0, 1'b0);
      add_op(bole_pkg::MODE_REMOVE, 32'sd1234, 4'd0, 1'b0, 1'b0);
      add_op(bole_pkg::MODE_REMOVE, 32'sd0, 4'd0, 1'b0, 1'b0);
      add_op(bole_pkg::MODE_POP_HEAD, 32'sd0, 4'd0, 1'b0, 1'b0);
      add_op(bole_pkg::MODE_POP_TAIL, 32'sd0, 4'd0, 1'b0, 1'b0);
      add_op(bole_pkg::MODE_REMOVE, 32'sh80000000, 4'd0, 1'b0, 1'b0);
      add_op(bole_pkg::MODE_REMOVE, 32'sh7fffffff, 4'd0, 1'b0, 1'b0);
      // single entry pops empty the list
      add_op(bole_pkg::MODE_POP_HEAD, 32'sd0, 4'd0, 1'b0, 1'b0);
      add_op(bole_pkg::MODE_PUSH_TAIL, 32'sd7, 4'd0, 1'b0, 1'b0);
      add_op(bole_pkg::MODE_POP_TAIL, 32'sd0, 4'd0, 1'b0, 1'b0);
      add_op(bole_pkg::MODE_READ, 32'sd0, 4'd0, 1'b0, 1'b0);

      // random: fill, drain and sorted-use phases over a small key pool
      gen_count  = 0;
      style      = 0;
      style_left = 0;
      for (i = 0; i < RANDOM_OPS; i++) begin
         drain = (i == 0) || (i == 600);
         if (style_left == 0) begin
            style      = $urandom_range(0, 2);
            style_left = $urandom_range(10, 60);
            if ($urandom_range(0, 4) == 0) drain = 1'b1;
         end
         style_left--;
         r = $urandom_range(0, 99);
         case (style)
            0: begin
               if (r < 22) m = bole_pkg::MODE_PUSH_TAIL;
               else if (r < 42) m = bole_pkg::MODE_PUSH_HEAD;
               else if (r < 72) m = bole_pkg::MODE_INSERT;
               else if (r < 86) m = bole_pkg::MODE_READ;
               else if (r < 94) m = bole_pkg::MODE_REMOVE;
               else if (r < 97) m = bole_pkg::MODE_POP_HEAD;
               else m = bole_pkg::MODE_POP_TAIL;
            end
            1: begin
               if (r < 6) m = bole_pkg::MODE_PUSH_TAIL;
               else if (r < 12) m = bole_pkg::MODE_PUSH_HEAD;
               else if (r < 20) m = bole_pkg::MODE_INSERT;
               else if (r < 45) m = bole_pkg::MODE_POP_HEAD;
               else if (r < 70) m = bole_pkg::MODE_POP_TAIL;
               else if (r < 86) m = bole_pkg::MODE_REMOVE;
               else m = bole_pkg::MODE_READ;
            end
            default: begin
               if (r < 45) m = bole_pkg::MODE_INSERT;
               else if (r < 68) m = bole_pkg::MODE_REMOVE;
               else if (r < 88) m = bole_pkg::MODE_READ;
               else if (r < 94) m = bole_pkg::MODE_POP_HEAD;
               else m = bole_pkg::MODE_POP_TAIL;
            end
         endcase
         if ($urandom_range(0, 49) == 0) m = MODE_UNUSED;

         r = (m == bole_pkg::MODE_REMOVE) ? $urandom_range(0, 5) : $urandom_range(0, 9);
         if (r < 4 && key_pool.size() != 0) begin
            k = key_pool[$urandom_range(0, key_pool.size() - 1)];
         end else if (r < 6) begin
            k = $urandom_range(0, 16);
            k = k - 8;
         end else if (r == 6) begin
            case ($urandom_range(0, 3))
               0: k = 32'sh7fffffff;
               1: k = 32'sh80000000;
               2: k = 32'sd0;
               default: k = -32'sd1;
            endcase
         end else begin
            k = $urandom;
         end

         if (m == bole_pkg::MODE_READ && gen_count > 0 && $urandom_range(0, 2) != 0)
            idx = 4'($urandom_range(0, gen_count - 1));
         else
            idx = 4'($urandom);

         if (m <= bole_pkg::MODE_INSERT) begin
            key_pool.push_back(k);
            if (key_pool.size() > 24) key_pool.delete(0);
            if (gen_count < DEPTH) gen_count++;
         end else if (m <= bole_pkg::MODE_REMOVE) begin
            if (gen_count > 0) gen_count--;
         end
         add_op(m, k, idx, (i == 300) || (i == 1000), drain);
      end

      @(negedge reset);
      while (job_backlog.size() != 0 || outcome_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (outcome_q.size() != 0) mismatches++;

      $display("ran %0d requests, %0d responses; by mode: %0d %0d %0d %0d %0d %0d %0d %0d",
               n_requests, n_responses, mode_seen[0], mode_seen[1], mode_seen[2],
               mode_seen[3], mode_seen[4], mode_seen[5], mode_seen[6], mode_seen[7]);
      $display("full %0d, empty %0d, miss %0d, peak occupancy %0d of %0d, mismatches %0d",
               n_full, n_empty, n_miss, peak_count, DEPTH, mismatches);
      if (mismatches == 0) begin
         $display("bounded_ordered_list_engine verification clean");
      end else begin
         $display("bounded_ordered_list_engine verification failed");
      end
      $finish;
   end

endmodule
